@@ rtl/core/gain_clip_overwrite_audio_ring_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the audio ring unit
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAIN_CLIP_OVERWRITE_AUDIO_RING_UNIT_ASSERT_SVH
`define GAIN_CLIP_OVERWRITE_AUDIO_RING_UNIT_ASSERT_SVH

// same-cycle implication
`define GCOR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gcor_pkg.sv @@
// ----------------------------------------------------------------------------
// gcor_pkg
// Shared constants, types and pointer helpers of the audio ring unit.
// ----------------------------------------------------------------------------
package gcor_pkg;

  localparam int RING_DEPTH = 8192;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 7;
  localparam int LIMIT_W    = 15;
  localparam int PEAK_W     = 15;
  localparam int FILL_W     = 13;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(8);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(22000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN,
    CFG_CLIP_LIMIT,
    CFG_MUTE
  } cfg_idx_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic                push;
    logic                rd_en;
    ptr_t                wr_addr;
    ptr_t                rd_addr;
    logic [FILL_W-1:0]   fill;
  } ring_cmd_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ring_fill(input ptr_t wp, input ptr_t rp);
    logic [PTR_W:0] sum;
    sum = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp})
                     : ({1'b0, wp} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rp});
    ring_fill = sum[PTR_W-1:0];
  endfunction

endpackage

@@ rtl/core/gcor_in_if.sv @@
// ----------------------------------------------------------------------------
// gcor_in_if
// Request channel: push or pull request with its sample and block marker.
// ----------------------------------------------------------------------------
interface gcor_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [gcor_pkg::SAMPLE_W-1:0] sample_in;
  logic                                block_end;

  modport source (output valid, output req_type, output sample_in, output block_end,
                  input ready);
  modport sink   (input valid, input req_type, input sample_in, input block_end,
                  output ready);
endinterface

@@ rtl/core/gcor_out_if.sv @@
// ----------------------------------------------------------------------------
// gcor_out_if
// Result channel: stereo frame, block peak and fill level.
// ----------------------------------------------------------------------------
interface gcor_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gcor_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [gcor_pkg::SAMPLE_W-1:0] right_sample;
  logic                                 sample_valid;
  logic [gcor_pkg::PEAK_W-1:0]          block_peak;
  logic                                 peak_valid;
  logic [gcor_pkg::FILL_W-1:0]          fill_level;

  modport source (output valid, output left_sample, output right_sample,
                  output sample_valid, output block_peak, output peak_valid,
                  output fill_level, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input sample_valid, input block_peak, input peak_valid,
                  input fill_level, output ready);
endinterface

@@ rtl/core/gcor_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gcor_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gcor_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gcor_pkg::CFG_IDX_W-1:0]    index;
  logic [gcor_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/gcor_sample_ram.sv @@
// ----------------------------------------------------------------------------
// gcor_sample_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gcor_sample_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/gcor_ring_ctrl.sv @@
// ----------------------------------------------------------------------------
// gcor_ring_ctrl
// Ring pointers: push advances the write pointer and drops the oldest sample
// when full, pull advances the read pointer unless muted or empty.
// ----------------------------------------------------------------------------
module gcor_ring_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                req_type,
  input  logic                mute,
  output gcor_pkg::ring_cmd_t cmd
);

  gcor_pkg::ptr_t wp_r, wp_nxt;
  gcor_pkg::ptr_t rp_r, rp_nxt;
  gcor_pkg::ptr_t wp_inc;

  always_comb begin
    wp_inc      = gcor_pkg::ring_next(wp_r);
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    cmd.push    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.wr_addr = wp_r;
    cmd.rd_addr = rp_r;
    if (accept) begin
      if (!req_type) begin
        cmd.push = 1'b1;
        wp_nxt   = wp_inc;
        if (wp_inc == rp_r) begin
          rp_nxt = gcor_pkg::ring_next(rp_r);
        end
      end else if (!mute && (wp_r != rp_r)) begin
        cmd.rd_en = 1'b1;
        rp_nxt    = gcor_pkg::ring_next(rp_r);
      end
    end
    cmd.fill = gcor_pkg::FILL_W'(gcor_pkg::ring_fill(wp_nxt, rp_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

endmodule

@@ rtl/core/gcor_peak_clip.sv @@
// ----------------------------------------------------------------------------
// gcor_peak_clip
// Symmetric clip of the gained sample and running block peak tracking.
// ----------------------------------------------------------------------------
module gcor_peak_clip (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [gcor_pkg::PROD_W-1:0]   prod,
  input  logic [gcor_pkg::LIMIT_W-1:0]         clip_limit,
  input  logic                                 step,
  input  logic                                 block_end,
  output logic signed [gcor_pkg::SAMPLE_W-1:0] sample_out,
  output logic [gcor_pkg::PEAK_W-1:0]          peak_out
);

  logic signed [gcor_pkg::PROD_W-1:0] lim_pos;
  logic signed [gcor_pkg::PROD_W-1:0] lim_neg;
  logic signed [gcor_pkg::PROD_W-1:0] clipped;
  logic signed [gcor_pkg::PROD_W-1:0] mag_full;
  logic [gcor_pkg::PEAK_W-1:0]        mag;
  logic [gcor_pkg::PEAK_W-1:0]        peak_r, peak_nxt;
  logic [gcor_pkg::PEAK_W-1:0]        peak_upd;

  always_comb begin
    lim_pos = gcor_pkg::PROD_W'($signed({1'b0, clip_limit}));
    lim_neg = -lim_pos;
    if (prod > lim_pos) begin
      clipped = lim_pos;
    end else if (prod < lim_neg) begin
      clipped = lim_neg;
    end else begin
      clipped = prod;
    end
    mag_full   = (clipped < 0) ? -clipped : clipped;
    mag        = mag_full[gcor_pkg::PEAK_W-1:0];
    sample_out = clipped[gcor_pkg::SAMPLE_W-1:0];
    peak_upd   = (mag > peak_r) ? mag : peak_r;
    peak_out   = peak_upd;
    peak_nxt   = peak_r;
    if (step) begin
      peak_nxt = block_end ? '0 : peak_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else begin
      peak_r <= peak_nxt;
    end
  end

endmodule

@@ rtl/core/gain_clip_overwrite_audio_ring_unit.sv @@
// ----------------------------------------------------------------------------
// gain_clip_overwrite_audio_ring_unit
// Mono ring buffer with gain and clip on push, stereo frame out on pull.
// ----------------------------------------------------------------------------
// Takes one request per clock unless the output stalls, and returns one result
// per request, in order, via the stage-1 and output registers. Pointers move in
// the accept cycle; the gained sample is clipped and written to the sample RAM
// when stage 1 advances, while a pull reads the RAM in its accept cycle, with a
// bypass when it reads the entry that is being written. The RAM has one write
// and one read port, so a push and a pull never compete. The RAM starts with
// unknown contents and needs no clearing pass; it holds RING_DEPTH-1 samples.
module gain_clip_overwrite_audio_ring_unit (
  input  logic         clk,
  input  logic         rst_n,
  gcor_in_if.sink      in_req,
  gcor_out_if.source   out_rsp,
  gcor_cfg_if.sink     cfg_wr
);

  `include "gain_clip_overwrite_audio_ring_unit_assert.svh"

  logic [gcor_pkg::GAIN_W-1:0]  gain_r;
  logic [gcor_pkg::LIMIT_W-1:0] clip_limit_r;
  logic                         mute_r;

  gcor_pkg::ring_cmd_t cmd;
  logic acc;
  logic adv;
  logic wr_now;
  logic fwd_nxt;

  logic                                 s1_v_r;
  logic                                 s1_push_r;
  logic                                 s1_rd_r;
  logic                                 s1_bend_r;
  logic signed [gcor_pkg::PROD_W-1:0]   s1_prod_r;
  gcor_pkg::ptr_t                       s1_waddr_r;
  logic [gcor_pkg::FILL_W-1:0]          s1_fill_r;
  logic                                 s1_fwd_r;
  logic signed [gcor_pkg::SAMPLE_W-1:0] s1_fwd_data_r;

  logic signed [gcor_pkg::PROD_W-1:0]   prod;
  logic signed [gcor_pkg::SAMPLE_W-1:0] clipped;
  logic [gcor_pkg::PEAK_W-1:0]          peak;
  logic [gcor_pkg::SAMPLE_W-1:0]        rdata;
  logic signed [gcor_pkg::SAMPLE_W-1:0] pull_data;

  logic                                 out_v_r;
  logic signed [gcor_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                                 out_svalid_r;
  logic [gcor_pkg::PEAK_W-1:0]          out_peak_r;
  logic                                 out_pvalid_r;
  logic [gcor_pkg::FILL_W-1:0]          out_fill_r;

  // configuration
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r       <= gcor_pkg::GAIN_RST;
      clip_limit_r <= gcor_pkg::LIMIT_RST;
      mute_r       <= 1'b0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        gcor_pkg::CFG_GAIN:       gain_r       <= cfg_wr.wdata[gcor_pkg::GAIN_W-1:0];
        gcor_pkg::CFG_CLIP_LIMIT: clip_limit_r <= cfg_wr.wdata[gcor_pkg::LIMIT_W-1:0];
        gcor_pkg::CFG_MUTE:       mute_r       <= cfg_wr.wdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv          = !out_v_r || out_rsp.ready;
  assign in_req.ready = !s1_v_r || adv;
  assign acc          = in_req.valid && in_req.ready;

  gcor_ring_ctrl u_ring_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (acc),
    .req_type (in_req.req_type),
    .mute     (mute_r),
    .cmd      (cmd)
  );

  assign prod = gcor_pkg::PROD_W'(in_req.sample_in * $signed({1'b0, gain_r}));

  // bypass the write that lands on the entry a new pull reads
  assign wr_now  = s1_v_r && s1_push_r && adv;
  assign fwd_nxt = cmd.rd_en && wr_now && (s1_waddr_r == cmd.rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_push_r     <= cmd.push;
      s1_rd_r       <= cmd.rd_en;
      s1_bend_r     <= in_req.block_end;
      s1_prod_r     <= prod;
      s1_waddr_r    <= cmd.wr_addr;
      s1_fill_r     <= cmd.fill;
      s1_fwd_r      <= fwd_nxt;
      s1_fwd_data_r <= clipped;
    end
  end

  gcor_peak_clip u_peak_clip (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod       (s1_prod_r),
    .clip_limit (clip_limit_r),
    .step       (wr_now),
    .block_end  (s1_bend_r),
    .sample_out (clipped),
    .peak_out   (peak)
  );

  gcor_sample_ram #(
    .DEPTH (gcor_pkg::RING_DEPTH),
    .WIDTH (gcor_pkg::SAMPLE_W)
  ) u_sample_ram (
    .clk   (clk),
    .we    (wr_now),
    .waddr (s1_waddr_r),
    .wdata (clipped),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rdata)
  );

  assign pull_data = s1_fwd_r ? s1_fwd_data_r : $signed(rdata);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && s1_v_r) begin
      out_v_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_sample_r <= s1_rd_r ? pull_data : '0;
      out_svalid_r <= s1_rd_r;
      out_peak_r   <= (s1_push_r && s1_bend_r) ? peak : '0;
      out_pvalid_r <= s1_push_r && s1_bend_r;
      out_fill_r   <= s1_fill_r;
    end
  end

  assign out_rsp.valid        = out_v_r;
  assign out_rsp.left_sample  = out_sample_r;
  assign out_rsp.right_sample = out_sample_r;
  assign out_rsp.sample_valid = out_svalid_r;
  assign out_rsp.block_peak   = out_peak_r;
  assign out_rsp.peak_valid   = out_pvalid_r;
  assign out_rsp.fill_level   = out_fill_r;

  `GCOR_ASSERT_NEXT(a_s1_hold, s1_v_r && !adv, s1_v_r && $stable(s1_prod_r), "stage 1 lost a stalled request")
  `GCOR_ASSERT_NOW(a_fwd_pull, s1_v_r && s1_fwd_r, !s1_push_r && s1_rd_r, "bypass on a request that does not read")
  `GCOR_ASSERT_NOW(a_out_kind, out_v_r && out_svalid_r, !out_pvalid_r, "sample and peak reported together")

endmodule
